// ===== rtl/dhpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhpm_pkg
// Shared types and codes for the Diffie-Hellman modular exponentiation party.
// ----------------------------------------------------------------------------
package dhpm_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIME = 2'd0,
        REG_GEN   = 2'd1,
        REG_EXP   = 2'd2
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam int PRIME_RESET = 23;
    localparam int GEN_RESET   = 5;
    localparam int EXP_RESET   = 6;

    // Request kinds.
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUBLIC = 2'd0,
        KIND_ABSORB = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_LOAD     = 3'd1,
        OP_INIT_MUL = 3'd2,
        OP_INIT_SQR = 3'd3,
        OP_STEP_RED = 3'd4,
        OP_STEP_MUL = 3'd5,
        OP_STEP_SQR = 3'd6,
        OP_FINISH   = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic cnt_done;
        logic exp_bit;
        logic exp_zero;
        logic mod_small;
        logic compute;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/dhpm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhpm_datapath
// Configuration registers, operand registers, the bit-serial modular
// multiply/reduce step, the stored shared key and the output register.
// ----------------------------------------------------------------------------
module dhpm_datapath
    import dhpm_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    input  logic [KIND_W-1:0]    kind,
    input  logic [WORD_BITS-1:0] value,
    input  logic                 out_ready,
    input  cmd_t                 cmd,
    output status_t              st,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] result_value,
    output logic                 key_match
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int SUM_W = WORD_BITS + 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] prime_reg;
    logic [WORD_BITS-1:0] gen_reg;
    logic [WORD_BITS-1:0] exp_cfg_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [WORD_BITS-1:0] key_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] result_reg;
    logic                 match_reg;

    logic [WORD_BITS-1:0] mult_x;
    logic [WORD_BITS-1:0] addend;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     m1;
    logic [SUM_W-1:0]     m2;
    logic [SUM_W-1:0]     diff1;
    logic [SUM_W-1:0]     diff2;
    logic [WORD_BITS-1:0] step_val;
    logic                 compute;
    logic                 mod_small;
    logic [WORD_BITS-1:0] final_val;

    // One step of (2*acc + addend) mod m; both terms are below m, so the
    // sum is below 3m and at most two subtractions of m are needed.
    always_comb
    begin
        mult_x = (cmd.op == OP_STEP_MUL) ? res_reg : base_reg;
        if (cmd.op == OP_STEP_RED)
        begin
            addend = WORD_BITS'(y_reg[WORD_BITS-1]);
        end
        else
        begin
            addend = y_reg[WORD_BITS-1] ? mult_x : '0;
        end
        sum   = SUM_W'({acc_reg, 1'b0}) + SUM_W'(addend);
        m1    = SUM_W'(m_reg);
        m2    = SUM_W'({m_reg, 1'b0});
        diff1 = sum - m1;
        diff2 = sum - m2;
        if (sum >= m2)
        begin
            step_val = diff2[WORD_BITS-1:0];
        end
        else if (sum >= m1)
        begin
            step_val = diff1[WORD_BITS-1:0];
        end
        else
        begin
            step_val = sum[WORD_BITS-1:0];
        end
    end

    assign compute   = (kind_reg == KIND_PUBLIC) || (kind_reg == KIND_ABSORB);
    assign mod_small = (m_reg < WORD_BITS'(2));
    assign final_val = (compute && !mod_small) ? res_reg : '0;

    assign st.cnt_done  = (cnt_reg == '0);
    assign st.exp_bit   = e_reg[0];
    assign st.exp_zero  = (e_reg == '0);
    assign st.mod_small = mod_small;
    assign st.compute   = compute;
    assign st.out_free  = !out_valid_reg || out_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg   <= WORD_BITS'(PRIME_RESET);
            gen_reg     <= WORD_BITS'(GEN_RESET);
            exp_cfg_reg <= WORD_BITS'(EXP_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRIME: prime_reg   <= cfg_data;
                REG_GEN:   gen_reg     <= cfg_data;
                REG_EXP:   exp_cfg_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg <= kind;
                m_reg    <= prime_reg;
                e_reg    <= exp_cfg_reg;
                y_reg    <= (kind == KIND_PUBLIC) ? gen_reg : value;
                acc_reg  <= '0;
                res_reg  <= WORD_BITS'(1);
                cnt_reg  <= CNT_LAST;
            end
            OP_INIT_MUL, OP_INIT_SQR:
            begin
                acc_reg <= '0;
                y_reg   <= base_reg;
                cnt_reg <= CNT_LAST;
            end
            OP_STEP_RED, OP_STEP_MUL, OP_STEP_SQR:
            begin
                if (cnt_reg == '0 && cmd.op == OP_STEP_MUL)
                begin
                    // The multiply always runs into the square of the
                    // same exponent bit, so set that square up here.
                    res_reg <= step_val;
                    acc_reg <= '0;
                    y_reg   <= base_reg;
                    cnt_reg <= CNT_LAST;
                end
                else
                begin
                    acc_reg <= step_val;
                    y_reg   <= {y_reg[WORD_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        base_reg <= step_val;
                        if (cmd.op == OP_STEP_SQR)
                        begin
                            e_reg <= {1'b0, e_reg[WORD_BITS-1:1]};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Stored shared key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cmd.op == OP_FINISH && kind_reg == KIND_ABSORB)
        begin
            key_reg <= final_val;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            result_reg <= final_val;
            match_reg  <= (kind_reg == KIND_CHECK) && (y_reg == key_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign key_match    = match_reg;

    a_step_mod_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_STEP_RED || cmd.op == OP_STEP_MUL || cmd.op == OP_STEP_SQR)
        |-> !mod_small)
        else $error("modular step issued with a modulus below two");

    a_key_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(key_reg) |-> $past(cmd.op == OP_FINISH && kind_reg == KIND_ABSORB))
        else $error("shared key changed outside an absorb completion");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |=> out_valid_reg)
        else $error("completed request did not raise out_valid");

endmodule

// ===== rtl/dhpm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhpm_ctrl
// Sequencer for square-and-multiply exponentiation.
// ----------------------------------------------------------------------------
module dhpm_ctrl
    import dhpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DISP = 6'b000010,
        S_RED  = 6'b000100,
        S_EXP  = 6'b001000,
        S_MUL  = 6'b010000,
        S_SQR  = 6'b100000
    } state_t;

    // All-zero code, which no one-hot state ever takes.
    localparam logic [5:0] UNUSED_CODES = 6'b000000;

    state_t state_reg;
    state_t state_next;
    logic   out_pend_reg;
    logic   out_pend_next;

    always_comb
    begin
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        cmd.op        = OP_NOP;
        in_ready      = 1'b0;
        if (out_pend_reg)
        begin
            // Waiting for the output register to free up.
            if (st.out_free)
            begin
                cmd.op        = OP_FINISH;
                out_pend_next = 1'b0;
                state_next    = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_DISP;
                    end
                end
                S_DISP:
                begin
                    if (st.compute && !st.mod_small)
                    begin
                        state_next = S_RED;
                    end
                    else
                    begin
                        out_pend_next = 1'b1;
                    end
                end
                S_RED:
                begin
                    cmd.op = OP_STEP_RED;
                    if (st.cnt_done)
                    begin
                        state_next = S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (st.exp_zero)
                    begin
                        out_pend_next = 1'b1;
                    end
                    else if (st.exp_bit)
                    begin
                        cmd.op     = OP_INIT_MUL;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.op     = OP_INIT_SQR;
                        state_next = S_SQR;
                    end
                end
                S_MUL:
                begin
                    cmd.op = OP_STEP_MUL;
                    if (st.cnt_done)
                    begin
                        state_next = S_SQR;
                    end
                end
                S_SQR:
                begin
                    cmd.op = OP_STEP_SQR;
                    if (st.cnt_done)
                    begin
                        state_next = S_EXP;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
        end
    end

    a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |=> (state_reg == S_DISP && !out_pend_reg))
        else $error("accepted request did not move to dispatch");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |-> (st.out_free && out_pend_reg))
        else $error("result written while the output register was busy");

    a_mul_then_sqr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && !out_pend_reg && st.cnt_done) |=> (state_reg == S_SQR))
        else $error("multiply did not run into the square");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != UNUSED_CODES) |-> !(in_ready && out_pend_reg))
        else $error("input taken while a result is pending");

endmodule

// ===== rtl/diffie_hellman_party_modexp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffie_hellman_party_modexp
// One Diffie-Hellman party: public value, shared key derivation and key check
// by exact square-and-multiply modular exponentiation.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   --------  ----------------------  -----------------------------------
//   in        in_valid / in_ready     kind, value
//   out       out_valid / out_ready   result_value, key_match
//   cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// A check request (kind 2) or an undefined kind goes from acceptance through
// the dispatch state to the result register without any exponentiation.
// The bit-serial modular multiply, one multiplier bit per cycle, is shared
// by the base reduction, the multiplies and the squares.
// Reset clears the controller, the output valid and the stored key, and loads
// the configuration registers with p = 23, g = 5, x = 6.
// A new request is taken once the previous one has reached the output
// register; a stalled output holds its result and blocks only completion.
//
module diffie_hellman_party_modexp
    import dhpm_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Request channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [WORD_BITS-1:0] value,

    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] result_value,
    output logic                 key_match,

    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    // The controller only issues operations; all values live in the datapath.
    cmd_t    cmd;
    status_t st;

    dhpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath latches the modulus, exponent and base at acceptance, so
    // configuration writes never disturb a request in flight.
    dhpm_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .value        (value),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .result_value (result_value),
        .key_match    (key_match)
    );

endmodule

// ===== bench/diffie_hellman_party_modexp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffie_hellman_party_modexp_tb
// Self-checking bench for the Diffie-Hellman party. A directed table covers the
// kinds and the corner cases under the reset settings. Random phases follow,
// each with its own modulus, generator and exponent, under random stalls on
// both channels. Results are checked against typed-in values or a modular
// exponentiation predictor kept in the bench.
// ----------------------------------------------------------------------------
module diffie_hellman_party_modexp_tb;
    import dhpm_pkg::*;

    localparam int WORD = 32;

    // Run shape. Each phase starts with a fresh set of register values.
    localparam int N_DIRECTED      = 14;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 31;

    // The watchdog allows the slowest exponentiation plus the long receiver
    // hold-off several times over.
    localparam int HOLD_OFF_CYCLES = 2500;
    localparam int SETTLE_CYCLES   = 2200;
    localparam int WATCHDOG_LIMIT  = 25000;

    // One result as seen on the output channel.
    typedef struct {
        logic [WORD-1:0] result_value;
        logic            key_match;
    } dh_result_t;

    // One row of the directed table. Where known is set, the expected result
    // is typed in and overrides the predictor.
    typedef struct {
        kind_t           kind;
        logic [WORD-1:0] value;
        bit              known;
        logic [WORD-1:0] want_value;
        bit              want_match;
    } directed_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind      = KIND_PUBLIC;
    logic [WORD-1:0]      value     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WORD-1:0]      result_value;
    logic                 key_match;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PRIME;
    logic [WORD-1:0]      cfg_data  = '0;

    // Bench copy of the block's registers and stored key.
    logic [WORD-1:0] modulus_reg   = WORD'(PRIME_RESET);
    logic [WORD-1:0] generator_reg = WORD'(GEN_RESET);
    logic [WORD-1:0] exponent_reg  = WORD'(EXP_RESET);
    logic [WORD-1:0] key_model     = '0;

    // Results still owed by the block, oldest first.
    dh_result_t pending_results[$];

    int  mismatch_count   = 0;
    int  quiet_cycles     = 0;
    bit  steady_mode      = 1'b0;
    bit  hold_off_request = 1'b0;

    diffie_hellman_party_modexp #(
        .WORD_BITS(WORD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .key_match    (key_match),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Exact modular exponentiation, right-to-left over every exponent bit.
    // Products of two reduced words fit in the double-width accumulator, so a
    // plain remainder gives the same value as the block's shift-and-add multiply.
    function automatic logic [WORD-1:0] mod_power(input logic [WORD-1:0] base,
                                                  input logic [WORD-1:0] expo,
                                                  input logic [WORD-1:0] modulus);
        logic [2*WORD-1:0] acc;
        logic [2*WORD-1:0] sq;
        logic [2*WORD-1:0] m;
        m = {{WORD{1'b0}}, modulus};
        // A modulus of zero or one collapses every power to zero.
        if (modulus < 2)
            return '0;
        sq  = {{WORD{1'b0}}, base} % m;
        acc = 1;
        for (int i = 0; i < WORD; i++)
        begin
            if (expo[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[WORD-1:0];
    endfunction

    // Works out the result of one accepted request and advances the key copy.
    function automatic dh_result_t predict_exchange(input kind_t k,
                                                    input logic [WORD-1:0] v);
        dh_result_t r;
        r.result_value = '0;
        r.key_match    = 1'b0;
        case (k)
            KIND_PUBLIC:
                r.result_value = mod_power(generator_reg, exponent_reg, modulus_reg);
            KIND_ABSORB:
            begin
                key_model      = mod_power(v, exponent_reg, modulus_reg);
                r.result_value = key_model;
            end
            KIND_CHECK:
                r.key_match = (v == key_model);
            default:
                ; // Undefined kind: both fields stay zero and nothing changes.
        endcase
        return r;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_mode || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD-1:0] want,
                                   input logic [WORD-1:0] got);
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Holds one request on the input channel until the block takes it, then
    // returns what the block must answer.
    task automatic offer_request(input kind_t k, input logic [WORD-1:0] v,
                                 output dh_result_t predicted);
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_exchange(k, v);
    endtask

    task automatic rest_sender(input int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every owed result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes all three registers on back-to-back cycles while the block idles.
    task automatic write_config(input logic [WORD-1:0] p, input logic [WORD-1:0] g,
                                input logic [WORD-1:0] x);
        cfg_idx_t        idx [3];
        logic [WORD-1:0] data [3];
        idx  = '{REG_PRIME, REG_GEN, REG_EXP};
        data = '{p, g, x};
        repeat (4) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            @(posedge clk);
        end
        cfg_we        <= 1'b0;
        modulus_reg   = p;
        generator_reg = g;
        exponent_reg  = x;
    endtask

    // Request side: reset, the directed table, then the random phases.
    initial
    begin
        directed_row_t   directed_rows [N_DIRECTED];
        dh_result_t      predicted;
        kind_t           next_kind;
        logic [WORD-1:0] next_value;
        logic [WORD-1:0] p;
        logic [WORD-1:0] g;
        logic [WORD-1:0] x;
        int unsigned     roll;

        // Under the reset settings p = 23, g = 5, x = 6 the public value is
        // 5^6 mod 23 = 8. Partner value 23 reduces to 0 and 24 to 1.
        directed_rows = '{
            '{KIND_CHECK,  32'h0000_0000, 1'b1, 32'h0, 1'b1}, // key check before exchange
            '{KIND_CHECK,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
            '{KIND_NONE,   32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0}, // undefined kind
            '{KIND_PUBLIC, 32'h0000_0000, 1'b1, 32'h8, 1'b0},
            '{KIND_ABSORB, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
            '{KIND_CHECK,  32'h0000_0000, 1'b1, 32'h0, 1'b1},
            '{KIND_ABSORB, 32'h0000_0008, 1'b0, 32'h0, 1'b0},
            '{KIND_ABSORB, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0}, // unreduced partner value
            '{KIND_CHECK,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{KIND_ABSORB, 32'h0000_0017, 1'b1, 32'h0, 1'b0}, // equals the modulus
            '{KIND_ABSORB, 32'h0000_0018, 1'b1, 32'h1, 1'b0}, // one above the modulus
            '{KIND_NONE,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
            '{KIND_CHECK,  32'h0000_0001, 1'b1, 32'h0, 1'b1}, // key survives the undefined kind
            '{KIND_CHECK,  32'h0000_0002, 1'b1, 32'h0, 1'b0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            offer_request(directed_rows[r].kind, directed_rows[r].value, predicted);
            if (directed_rows[r].known)
            begin
                predicted.result_value = directed_rows[r].want_value;
                predicted.key_match    = directed_rows[r].want_match;
            end
            pending_results.push_back(predicted);
            rest_sender(pick_idle());
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            // Register settings per phase, extremes first.
            case (phase)
                0:
                begin
                    p = 32'h0;          // degenerate modulus
                    g = $urandom();
                    x = $urandom_range(0, 63);
                end
                1:
                begin
                    p = 32'h1;          // degenerate modulus
                    g = $urandom();
                    x = $urandom_range(0, 63);
                end
                2:
                begin
                    p = 32'h2;          // smallest real modulus, zero exponent
                    g = 32'hFFFF_FFFF;
                    x = 32'h0;
                end
                3:
                begin
                    p = 32'hFFFF_FFFF;  // exponent of one still reduces the base
                    g = 32'hFFFF_FFFF;
                    x = 32'h1;
                end
                4:
                begin
                    p = 32'hFFFF_FFFF;  // slowest case: every exponent bit set
                    g = $urandom();
                    x = 32'hFFFF_FFFF;
                end
                5:
                begin
                    p = 32'hFFFF_FFFB;
                    g = 32'h2;
                    x = $urandom();
                end
                6:
                begin
                    p = $urandom_range(2, 65535);
                    g = $urandom();
                    x = $urandom_range(0, 1023);
                end
                7:
                begin
                    p = $urandom() | 32'h8000_0000;
                    g = $urandom();
                    x = $urandom() & 32'h0000_FFFF;
                end
                default:
                begin
                    p = $urandom_range(2, 1000);
                    g = 32'h0;
                    x = $urandom_range(0, 255);
                end
            endcase

            wait_for_results();
            write_config(p, g, x);

            // One phase runs with no idling at all; another starts with a long
            // receiver hold-off so the block backs up into the request channel.
            steady_mode = (phase == 7);
            if (phase == 6)
                hold_off_request = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Mostly proper exchanges: public value, absorb a partner
                // value, then key checks that often hit the stored key.
                roll       = $urandom_range(0, 99);
                next_value = $urandom();
                if (roll < 25)
                    next_kind = KIND_PUBLIC;
                else if (roll < 50)
                begin
                    next_kind = KIND_ABSORB;
                    roll      = $urandom_range(0, 3);
                    if (roll == 0 && modulus_reg != 0)
                        next_value = $urandom() % modulus_reg;
                    else if (roll == 1)
                        next_value = mod_power(generator_reg, $urandom_range(1, 200),
                                               modulus_reg);
                end
                else if (roll < 88)
                begin
                    next_kind = KIND_CHECK;
                    roll      = $urandom_range(0, 3);
                    if (roll < 2)
                        next_value = key_model;
                    else if (roll == 2)
                        next_value = key_model ^ (32'h1 << $urandom_range(0, WORD - 1));
                end
                else
                    next_kind = KIND_NONE;

                offer_request(next_kind, next_value, predicted);
                pending_results.push_back(predicted);

                // Halfway through the last phase the sender waits for the
                // block to empty completely before going on.
                if (phase == N_PHASES - 1 && n == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                else
                    rest_sender(pick_idle());
            end
        end

        steady_mode = 1'b0;
        wait_for_results();
        // Give a stray extra result time to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("diffie_hellman_party_modexp verification clean");
        else
            $display("diffie_hellman_party_modexp verification failed");
        $finish;
    end

    // Result side: random ready pattern, plus the one long hold-off, which is
    // counted here rather than by the sender.
    initial
    begin
        int unsigned run_len;
        int unsigned gap_len;
        bit          hold_off_taken;
        hold_off_taken = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_request && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                run_len = $urandom_range(1, 24);
                out_ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                gap_len = pick_idle();
                if (gap_len != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap_len) @(posedge clk);
                end
            end
        end
    end

    // Result checker and watchdog. Outputs are sampled at the clock edge,
    // before the block updates them.
    always @(posedge clk)
    begin
        dh_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no request pending", '0, result_value);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_value !== want.result_value)
                        report_mismatch("result_value", want.result_value, result_value);
                    if (key_match !== want.key_match)
                        report_mismatch("key_match", WORD'(want.key_match),
                                        WORD'(key_match));
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
                $display("diffie_hellman_party_modexp verification failed");
                $finish;
            end
        end
    end

endmodule
